/* hdl/set_assoc_lru_cache_tags_macros.svh */
// Assertion macros for the cache tag block and its port checker.
// Depends on clk and rst being visible where a macro is used.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SALC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/salc_pkg.sv */
// Shared types and constants for the set-associative LRU cache tag block.
// No dependencies; used by the top level and its port checker.
package salc_pkg;

  // Default geometry.
  localparam int DEF_SETS       = 64;
  localparam int DEF_WAYS       = 4;
  localparam int DEF_BLOCK_BITS = 4;
  localparam int DEF_ADDR_BITS  = 32;

  // Fixed field widths of the stream payloads.
  localparam int ADDR_W     = 32;
  localparam int SET_OUT_W  = 6;
  localparam int WAY_OUT_W  = 2;
  localparam int TAG_OUT_W  = 22;
  localparam int CNT_W      = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 96;

  // Result field positions in m_tdata.
  localparam int HIT_BIT    = 0;
  localparam int SET_LSB    = 1;
  localparam int WAY_LSB    = SET_LSB + SET_OUT_W;
  localparam int EVICT_BIT  = WAY_LSB + WAY_OUT_W;
  localparam int EVTAG_LSB  = EVICT_BIT + 1;
  localparam int EVTAG_MSB  = EVTAG_LSB + TAG_OUT_W - 1;
  localparam int HCNT_LSB   = EVTAG_MSB + 1;
  localparam int MCNT_LSB   = HCNT_LSB + CNT_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } salc_state_t;

endpackage

/* hdl/set_assoc_lru_cache_tags.sv */
// Set-associative cache tag lookup with true LRU replacement, one memory row per set.
// The set row is read as the request is taken, and the result is registered once the
// output register is free; no new request is taken until the set row is written back.
// A finished result may wait on m_tready while the next request is taken.
// Reset: rst clears counters and control, then a clearing pass writes one set row a cycle
// through all SETS rows (64 by default) with s_tready low. Depends on salc_pkg.
module set_assoc_lru_cache_tags
  import salc_pkg::*;
#(
  parameter int SETS       = DEF_SETS,
  parameter int WAYS       = DEF_WAYS,
  parameter int BLOCK_BITS = DEF_BLOCK_BITS,
  parameter int ADDR_BITS  = DEF_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // request stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] address
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [0] hit, [6:1] set_index, [8:7] way,
                                           // [9] evicted, [31:10] evicted_tag,
                                           // [63:32] hit_count, [95:64] miss_count
);

  // Geometry derived from the parameters.
  localparam int SET_BITS = $clog2(SETS);
  localparam int SET_W    = (SETS > 1) ? SET_BITS : 1;
  localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int EFF_W    = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int SHIFT    = BLOCK_BITS + SET_BITS;
  localparam int TAG_W    = (EFF_W > SHIFT) ? EFF_W - SHIFT : 1;

  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - EFF_W);
  localparam logic [ADDR_W-1:0] IDX_MASK  = ADDR_W'((64'd1 << SET_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] SETS_A    = ADDR_W'(SETS);
  localparam logic [RANK_W-1:0] LRU_RANK  = RANK_W'(WAYS - 1);
  localparam logic [SET_W-1:0]  LAST_SET  = SET_W'(SETS - 1);

  // One memory word holds a whole set: valid, tag and rank of each way.
  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } way_ent_t;

  typedef way_ent_t [WAYS-1:0] row_t;

  row_t mem [SETS];

  salc_state_t       state, state_next;
  logic [SET_W-1:0]  clr_row;
  logic [SET_W-1:0]  req_set;
  logic [TAG_W-1:0]  req_tag;
  row_t              rd_row;
  logic [CNT_W-1:0]  hit_cnt, miss_cnt;

  // Address decode of the incoming request.
  logic [ADDR_W-1:0] addr_m, idx_field, idx_mod, tag_full;
  logic [SET_W-1:0]  set_in;
  logic [TAG_W-1:0]  tag_in;

  // Memory port controls.
  logic              rd_en, wr_en;
  logic [SET_W-1:0]  wr_addr;
  row_t              wr_row, clr_val, upd_row;

  // Lookup results.
  logic              go;
  logic              hit, any_inv, evicted;
  logic [RANK_W-1:0] hit_way, inv_way, lru_way, sel_way, sel_rank;
  logic [TAG_W-1:0]  ev_tag;
  logic [CNT_W-1:0]  hit_cnt_next, miss_cnt_next;
  logic [ADDR_W-1:0] set_ext, way_ext, tag_ext;

  // Split the address: drop the block offset, reduce the index field to a set
  // (one subtract covers a set count that is not a power of two), keep the rest as tag.
  always_comb begin
    addr_m    = s_tdata[ADDR_W-1:0] & ADDR_MASK;
    idx_field = (addr_m >> BLOCK_BITS) & IDX_MASK;
    idx_mod   = (idx_field >= SETS_A) ? idx_field - SETS_A : idx_field;
    set_in    = idx_mod[SET_W-1:0];
    tag_full  = addr_m >> SHIFT;
    tag_in    = tag_full[TAG_W-1:0];
  end

  // Reset row: nothing valid, tags clear, rank of each way equal to its index.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      clr_val[w].valid = 1'b0;
      clr_val[w].tag   = '0;
      clr_val[w].rank  = RANK_W'(w);
    end
  end

  // Tag compare and victim choice on the row read back from memory.
  always_comb begin
    hit     = 1'b0;
    any_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    lru_way = '0;
    // Walk down so the lowest-numbered way wins each search.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rd_row[w].valid && (rd_row[w].tag == req_tag)) begin
        hit     = 1'b1;
        hit_way = RANK_W'(w);
      end
      if (!rd_row[w].valid) begin
        any_inv = 1'b1;
        inv_way = RANK_W'(w);
      end
      // Ranks stay a permutation, so the oldest way carries the top rank.
      if (rd_row[w].rank == LRU_RANK) begin
        lru_way = RANK_W'(w);
      end
    end

    if (hit) begin
      sel_way = hit_way;
    end else if (any_inv) begin
      sel_way = inv_way;
    end else begin
      sel_way = lru_way;
    end

    evicted  = !hit && !any_inv;
    sel_rank = rd_row[sel_way].rank;
    ev_tag   = evicted ? rd_row[sel_way].tag : '0;

    // Promote the accessed way; ways that were more recent age by one.
    for (int w = 0; w < WAYS; w++) begin
      upd_row[w] = rd_row[w];
      if (RANK_W'(w) == sel_way) begin
        upd_row[w].rank = '0;
        if (!hit) begin
          upd_row[w].valid = 1'b1;
          upd_row[w].tag   = req_tag;
        end
      end else if (rd_row[w].rank < sel_rank) begin
        upd_row[w].rank = rd_row[w].rank + RANK_W'(1);
      end
    end

    // Saturating counters.
    hit_cnt_next  = hit_cnt;
    miss_cnt_next = miss_cnt;
    if (hit) begin
      if (hit_cnt != '1) hit_cnt_next = hit_cnt + CNT_W'(1);
    end else begin
      if (miss_cnt != '1) miss_cnt_next = miss_cnt + CNT_W'(1);
    end

    set_ext = ADDR_W'(req_set);
    way_ext = ADDR_W'(sel_way);
    tag_ext = ADDR_W'(ev_tag);
  end

  // Sequencer: clear the memory, take a request, then finish it once the
  // output register is free. The write-back lands before the next read is
  // issued, so back-to-back hits on one set need no forwarding.
  assign s_tready = (state == ST_IDLE);
  assign go       = (state == ST_LOOKUP) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = req_set;
    wr_row     = upd_row;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_row;
        wr_row  = clr_val;
        if (clr_row == LAST_SET) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          rd_en      = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (go) begin
          wr_en      = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_row <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_row <= clr_row + SET_W'(1);
    end
  end

  // Set row memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (rd_en) rd_row <= mem[set_in];
  end

  // Hold the decoded request for the lookup cycle.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_set <= set_in;
      req_tag <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt  <= '0;
      miss_cnt <= '0;
    end else if (go) begin
      hit_cnt  <= hit_cnt_next;
      miss_cnt <= miss_cnt_next;
    end
  end

  // Output register: load on completion, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata[HIT_BIT]                       <= hit;
      m_tdata[WAY_LSB-1:SET_LSB]             <= set_ext[SET_OUT_W-1:0];
      m_tdata[EVICT_BIT-1:WAY_LSB]           <= way_ext[WAY_OUT_W-1:0];
      m_tdata[EVICT_BIT]                     <= evicted;
      m_tdata[EVTAG_MSB:EVTAG_LSB]           <= tag_ext[TAG_OUT_W-1:0];
      m_tdata[MCNT_LSB-1:HCNT_LSB]           <= hit_cnt_next;
      m_tdata[OUT_DATA_W-1:MCNT_LSB]         <= miss_cnt_next;
    end
  end

endmodule

/* hdl/salc_checker.sv */
// Port checker for the cache tag block, bound to its top level.
// Depends on salc_pkg and set_assoc_lru_cache_tags_macros.svh.
`include "set_assoc_lru_cache_tags_macros.svh"

module salc_checker
  import salc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  `SALC_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                    m_tvalid && $stable(m_tdata), "result changed while stalled")

  `SALC_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready,
                    "request taken during lookup")

  `SALC_ASSERT_NOW(a_result_follows, $rose(m_tvalid), $past(s_tvalid && s_tready, 2),
                   "result without a request two cycles back")

  `SALC_ASSERT_NOW(a_hit_no_evict, m_tvalid && m_tdata[HIT_BIT], !m_tdata[EVICT_BIT],
                   "eviction reported on a hit")

  `SALC_ASSERT_NOW(a_evtag_zero, m_tvalid && !m_tdata[EVICT_BIT],
                   m_tdata[EVTAG_MSB:EVTAG_LSB] == '0, "evicted tag set without eviction")

endmodule

bind set_assoc_lru_cache_tags salc_checker u_salc_checker (.*);

/* dv/tb_set_assoc_lru_cache_tags.sv */
// Self-checking bench for set_assoc_lru_cache_tags: a directed table of accesses, then biased
// random accesses, each result checked against an LRU tag model kept inside the bench or, on
// pinned rows, a hand-written result. Depends on salc_pkg and the set_assoc_lru_cache_tags RTL.
module tb_set_assoc_lru_cache_tags;
  timeunit 1ns;
  timeprecision 1ps;
  import salc_pkg::*;

  localparam int SET_BITS     = $clog2(DEF_SETS);
  localparam int TAG_LSB      = DEF_BLOCK_BITS + SET_BITS;
  localparam int RANDOM_ITEMS = 850;
  localparam int LIMIT_CYCLES = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int SETTLE       = 10;
  localparam int POOL_TAGS    = 6;
  localparam int HOT_SETS     = 4;

  // One result of the block, field for field.
  typedef struct packed {
    logic                 hit;
    logic [SET_OUT_W-1:0] set_index;
    logic [WAY_OUT_W-1:0] way;
    logic                 evicted;
    logic [TAG_OUT_W-1:0] evicted_tag;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
  } access_result_t;

  // One row of stimulus; pinned rows carry a hand-written result instead of a predicted one.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              pinned;
    access_result_t    pinned_res;
  } access_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [31:0] address
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [0] hit, [6:1] set_index, [8:7] way, [9] evicted,
                                         // [31:10] evicted_tag, [63:32] hit_count,
                                         // [95:64] miss_count

  always #1 clk = ~clk;

  set_assoc_lru_cache_tags dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Tag model: valid bits, tags and recency ranks per set and way (rank 0 = most recent).
  bit                   line_valid [DEF_SETS][DEF_WAYS];
  logic [TAG_OUT_W-1:0] line_tag   [DEF_SETS][DEF_WAYS];
  logic [WAY_OUT_W-1:0] line_rank  [DEF_SETS][DEF_WAYS];
  logic [CNT_W-1:0]     hit_total  = '0;
  logic [CNT_W-1:0]     miss_total = '0;
  int                   evictions_seen = 0;

  access_row_t    access_rows[$];
  access_result_t pending_results[$];

  int sent = 0;          // index of the next request to offer
  int received = 0;
  int mismatches = 0;
  int n_directed = 0;
  int pause_a = 0;       // request indices at which the sender drains the block first
  int pause_b = 0;
  int steady_lo = 0;     // request window run with no idling on either side
  int steady_hi = 0;
  int burst_left = 1;
  int gap_left = 0;
  int stall_left = 0;
  int cycles = 0;

  // Look the address up, update the model and return the result the block must give.
  task automatic lookup_and_update(input logic [ADDR_W-1:0] addr, output access_result_t res);
    int                   s;
    int                   victim;
    logic [TAG_OUT_W-1:0] t;
    logic [WAY_OUT_W-1:0] r;
    s = int'(addr[TAG_LSB-1:DEF_BLOCK_BITS]);
    t = addr[ADDR_W-1:TAG_LSB];
    victim = -1;
    res = '0;
    res.set_index = addr[TAG_LSB-1:DEF_BLOCK_BITS];
    for (int w = 0; w < DEF_WAYS; w++) begin
      if (victim < 0 && line_valid[s][w] && line_tag[s][w] == t) victim = w;
    end
    if (victim >= 0) begin
      res.hit = 1'b1;
      if (hit_total != '1) hit_total++;
    end else begin
      if (miss_total != '1) miss_total++;
      // fill the first empty way, else replace the least recent one
      for (int w = 0; w < DEF_WAYS; w++) begin
        if (victim < 0 && !line_valid[s][w]) victim = w;
      end
      if (victim < 0) begin
        victim = 0;
        for (int w = 1; w < DEF_WAYS; w++) begin
          if (line_rank[s][w] > line_rank[s][victim]) victim = w;
        end
        res.evicted = 1'b1;
        res.evicted_tag = line_tag[s][victim];
        evictions_seen++;
      end
      line_valid[s][victim] = 1'b1;
      line_tag[s][victim] = t;
    end
    // promote the accessed way; everything more recent than it ages by one
    r = line_rank[s][victim];
    for (int w = 0; w < DEF_WAYS; w++) begin
      if (line_rank[s][w] < r) line_rank[s][w]++;
    end
    line_rank[s][victim] = '0;
    res.way = WAY_OUT_W'(victim);
    res.hit_count = hit_total;
    res.miss_count = miss_total;
  endtask

  function automatic void add_row(logic [ADDR_W-1:0] addr, bit pinned = 1'b0,
                                  access_result_t res = '0);
    access_rows.push_back('{addr: addr, pinned: pinned, pinned_res: res});
  endfunction

  // Timeout guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles: %0d requests sent, %0d results pending",
               cycles, sent, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Both stream sides, sampled and driven at the rising edge. All outputs are read before any
  // nonblocking update of this edge lands, so the result never depends on process order.
  always @(posedge clk) begin : stream_io
    access_result_t expected;
    access_result_t actual;
    access_result_t predicted;
    bit             bad;
    bit             steady;
    bit             pause_now;
    if (!rst) begin
      // Result side: compare every accepted result with the oldest expectation.
      if (m_tvalid && m_tready) begin
        actual.hit         = m_tdata[HIT_BIT];
        actual.set_index   = m_tdata[SET_LSB +: SET_OUT_W];
        actual.way         = m_tdata[WAY_LSB +: WAY_OUT_W];
        actual.evicted     = m_tdata[EVICT_BIT];
        actual.evicted_tag = m_tdata[EVTAG_LSB +: TAG_OUT_W];
        actual.hit_count   = m_tdata[HCNT_LSB +: CNT_W];
        actual.miss_count  = m_tdata[MCNT_LSB +: CNT_W];
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Unexpected result %0d at cycle %0d: m_tdata=%h", received, cycles,
                     m_tdata);
        end else begin
          expected = pending_results.pop_front();
          bad = (actual.hit !== expected.hit) || (actual.set_index !== expected.set_index) ||
                (actual.way !== expected.way) || (actual.evicted !== expected.evicted) ||
                (actual.evicted_tag !== expected.evicted_tag) ||
                (actual.hit_count !== expected.hit_count) ||
                (actual.miss_count !== expected.miss_count);
          if (bad) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
              $display("Mismatch on result %0d (cycle %0d)", received, cycles);
              $display("  expected hit=%0d set=%0d way=%0d evicted=%0d tag=%h hits=%0d misses=%0d",
                       expected.hit, expected.set_index, expected.way, expected.evicted,
                       expected.evicted_tag, expected.hit_count, expected.miss_count);
              $display("  actual   hit=%0d set=%0d way=%0d evicted=%0d tag=%h hits=%0d misses=%0d",
                       actual.hit, actual.set_index, actual.way, actual.evicted,
                       actual.evicted_tag, actual.hit_count, actual.miss_count);
            end
          end
        end
        received++;
      end

      // Request side: on acceptance, predict and queue the result, then advance.
      if (s_tvalid && s_tready) begin
        lookup_and_update(s_tdata, predicted);
        pending_results.push_back(access_rows[sent].pinned ? access_rows[sent].pinned_res
                                                           : predicted);
        sent++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = $urandom_range(0, 8);
        end
      end else if (!s_tvalid && gap_left > 0) begin
        gap_left--;
      end

      steady = (sent >= steady_lo) && (sent < steady_hi);
      if (steady) gap_left = 0;
      pause_now = (sent == pause_a || sent == pause_b) && (pending_results.size() != 0);

      // Hold a request that is still waiting; otherwise offer the next one or idle.
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (sent < access_rows.size() && gap_left == 0 && !pause_now) begin
        s_tvalid <= 1'b1;
        s_tdata <= access_rows[sent].addr;
      end else begin
        s_tvalid <= 1'b0;
      end

      // Receiver: always ready in the steady window; else mostly ready with short drops, now and then a longer stall.
      if (steady) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        stall_left = $urandom_range(2, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin : run
    logic [TAG_OUT_W-1:0]      tag_pool [POOL_TAGS];
    logic [SET_OUT_W-1:0]      hot_set  [HOT_SETS];
    logic [ADDR_W-1:0]         addr;
    logic [ADDR_W-1:0]         last_addr;
    int                        kind;

    // Model reset state: all invalid, rank of each way equals its index.
    for (int s = 0; s < DEF_SETS; s++) begin
      for (int w = 0; w < DEF_WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        line_tag[s][w] = '0;
        line_rank[s][w] = WAY_OUT_W'(w);
      end
    end

    // Directed part. First accesses after reset have results readable by hand.
    add_row(32'h0000_0000, 1'b1, '{hit: 1'b0, set_index: 6'd0, way: 2'd0, evicted: 1'b0,
                                   evicted_tag: 22'd0, hit_count: 32'd0, miss_count: 32'd1});
    add_row(32'h0000_000F, 1'b1, '{hit: 1'b1, set_index: 6'd0, way: 2'd0, evicted: 1'b0,
                                   evicted_tag: 22'd0, hit_count: 32'd1, miss_count: 32'd1});
    add_row(32'hFFFF_FFFF, 1'b1, '{hit: 1'b0, set_index: 6'd63, way: 2'd0, evicted: 1'b0,
                                   evicted_tag: 22'd0, hit_count: 32'd1, miss_count: 32'd2});
    add_row(32'h0000_03F0, 1'b1, '{hit: 1'b0, set_index: 6'd63, way: 2'd1, evicted: 1'b0,
                                   evicted_tag: 22'd0, hit_count: 32'd1, miss_count: 32'd3});
    // fill set 0, then force replacements, one of them of a zero tag
    add_row(32'h0000_0400);
    add_row(32'h0000_0800);
    add_row(32'h0000_0C00);
    add_row(32'h0000_1000);
    add_row(32'h0000_0404);
    add_row(32'hFFFF_FC00);
    add_row(32'h0000_0000);
    // set 63: hit on the all-ones tag, fill the rest, then evict
    add_row(32'hFFFF_FFF0);
    add_row(32'h5555_57F0);
    add_row(32'hAAAA_ABF0);
    add_row(32'h0000_07F0);
    add_row(32'h0000_03FF);
    // top address bit on and off, back-to-back hits in one set
    add_row(32'h8000_0000);
    add_row(32'h7FFF_FFFF);
    add_row(32'h1234_5678);
    add_row(32'h1234_5670);
    add_row(32'h1234_5678);
    n_directed = access_rows.size();

    // Random part: mostly a small pool of tags over a few hot sets, so hits, fills and
    // replacements all recur; the rest is wide-open addresses and near repeats.
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < POOL_TAGS; i++) tag_pool[i] = TAG_OUT_W'($urandom);
    hot_set[0] = '0;
    hot_set[1] = '1;
    for (int i = 2; i < HOT_SETS; i++) hot_set[i] = SET_OUT_W'($urandom_range(1, DEF_SETS - 2));
    last_addr = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 200 == 199) tag_pool[$urandom_range(2, POOL_TAGS - 1)] = TAG_OUT_W'($urandom);
      kind = $urandom_range(0, 99);
      if (kind < 70)
        addr = {tag_pool[$urandom_range(0, POOL_TAGS - 1)],
                hot_set[$urandom_range(0, HOT_SETS - 1)],
                DEF_BLOCK_BITS'($urandom_range(0, (1 << DEF_BLOCK_BITS) - 1))};
      else if (kind < 85)
        addr = $urandom;
      else
        addr = last_addr ^ ADDR_W'($urandom_range(0, (1 << DEF_BLOCK_BITS) - 1));
      add_row(addr);
      last_addr = addr;
    end

    pause_a = n_directed;
    pause_b = n_directed + RANDOM_ITEMS / 2;
    steady_lo = n_directed + 600;
    steady_hi = n_directed + 720;

    // Hold reset, then release it; the block then runs its clearing pass with s_tready low.
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go in and every result to come back, then let it settle.
    do @(negedge clk);
    while (!(sent == access_rows.size() && pending_results.size() == 0));
    repeat (SETTLE) @(negedge clk);

    $display("Ran %0d accesses (%0d directed, rest random) with bursty input and stalling output",
             sent, n_directed);
    $display("Seen %0d hits, %0d misses, %0d replacements; %0d results checked, %0d mismatches",
             hit_total, miss_total, evictions_seen, received, mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/salc_pkg.sv
hdl/set_assoc_lru_cache_tags.sv
hdl/salc_checker.sv
dv/tb_set_assoc_lru_cache_tags.sv
